// ===== rtl/core/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Shared types and constants for the command decoder, the command queue and
// the pin sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int DelayW     = 16;
  localparam int ByteW      = 8;
  localparam int AddrW      = 7;
  localparam int OpW        = 2;
  localparam int StatusW    = 2;
  localparam int BitIdxW    = 4;
  // Number of entries in the queue between decoder and sequencer (power of two).
  localparam int QueueDepth = 2;

  localparam logic [BitIdxW-1:0] BitsPerByte = BitIdxW'(8);
  localparam logic [DelayW-1:0]  DelayReset  = DelayW'(5);

  // Operation codes as they arrive on the input port.
  localparam logic [OpW-1:0] OP_TICK  = 2'd0;
  localparam logic [OpW-1:0] OP_ADDR  = 2'd1;
  localparam logic [OpW-1:0] OP_WRITE = 2'd2;
  localparam logic [OpW-1:0] OP_READ  = 2'd3;

  // Completion status codes.
  localparam logic [StatusW-1:0] STATUS_OK     = 2'd0;
  localparam logic [StatusW-1:0] STATUS_NACK   = 2'd1;
  localparam logic [StatusW-1:0] STATUS_REJECT = 2'd2;

  // Decoded request kind.
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_ADDR  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  // Pin sequencer phases.
  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START_A   = 4'd1,
    PH_START_B   = 4'd2,
    PH_WBIT_LOW  = 4'd3,
    PH_WBIT_HIGH = 4'd4,
    PH_WACK_LOW  = 4'd5,
    PH_WACK_HIGH = 4'd6,
    PH_RBIT_HIGH = 4'd7,
    PH_RBIT_LOW  = 4'd8,
    PH_RACK_LOW  = 4'd9,
    PH_RACK_HIGH = 4'd10,
    PH_STOP_A    = 4'd11,
    PH_STOP_B    = 4'd12,
    PH_STOP_C    = 4'd13
  } phase_e;

  // One decoded request as it travels through the queue.
  typedef struct packed {
    cmd_e             kind;
    logic             sda_in;
    logic [ByteW-1:0] byte_val;
    logic             rnw;
    logic             stop;
  } cmd_t;

endpackage

// ===== rtl/core/i2cm_front.sv =====
// ----------------------------------------------------------------------------
// I2C master command decoder
// Accepts input requests, classifies the operation and prepares the byte to
// shift out, then pushes the decoded request into the command queue.
// ----------------------------------------------------------------------------
module i2cm_front import i2cm_pkg::*; (
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [OpW-1:0]   operation_i,
  input  logic             sda_in_i,
  input  logic [AddrW-1:0] address_i,
  input  logic             read_not_write_i,
  input  logic [ByteW-1:0] write_data_i,
  input  logic             stop_after_i,
  input  logic             queue_ready_i,
  output logic             push_o,
  output cmd_t             cmd_o
);

  // Handshake: the queue decides whether a request can enter.
  assign in_stall_o = !queue_ready_i;
  assign push_o     = in_valid_i && queue_ready_i;

  // Classify the operation and build the outgoing byte.
  always_comb begin
    cmd_o.sda_in   = sda_in_i;
    cmd_o.rnw      = read_not_write_i;
    cmd_o.stop     = stop_after_i;
    cmd_o.byte_val = write_data_i;
    case (operation_i)
      OP_TICK: begin
        cmd_o.kind = CMD_TICK;
      end
      OP_ADDR: begin
        cmd_o.kind     = CMD_ADDR;
        cmd_o.byte_val = {address_i, read_not_write_i};
      end
      OP_WRITE: begin
        cmd_o.kind = CMD_WRITE;
      end
      OP_READ: begin
        cmd_o.kind = CMD_READ;
      end
      default: begin
        cmd_o.kind = CMD_TICK;
      end
    endcase
  end

endmodule

// ===== rtl/core/i2cm_queue.sv =====
// ----------------------------------------------------------------------------
// I2C master command queue
// Short FIFO between the decoder and the pin sequencer so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
module i2cm_queue import i2cm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic ready_o,
  output logic valid_o,
  input  logic pop_i,
  output cmd_t pop_data_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [CntW-1:0] Full = CntW'(QueueDepth);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign ready_o    = (count_q != Full);
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/i2cm_seq.sv =====
// ----------------------------------------------------------------------------
// I2C master pin sequencer
// Takes one decoded request per cycle while the output register is not stalled,
// advances the SCL/SDA sequence and registers the result for the output channel.
// ----------------------------------------------------------------------------
module i2cm_seq import i2cm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [DelayW-1:0]  delay_ticks_i,
  input  logic               cmd_valid_i,
  input  cmd_t               cmd_i,
  output logic               cmd_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               scl_out_o,
  output logic               sda_out_o,
  output logic               busy_res_o,
  output logic               done_res_o,
  output logic [StatusW-1:0] status_o,
  output logic [ByteW-1:0]   read_data_o,
  output logic               bus_open_o
);

  phase_e             phase_q, phase_d;
  logic [DelayW-1:0]  wait_q, wait_d;
  logic [BitIdxW-1:0] bit_q, bit_d;
  logic [ByteW-1:0]   shift_q, shift_d;
  logic               scl_q, scl_d;
  logic               sda_q, sda_d;
  logic               open_q, open_d;
  logic               reading_q, reading_d;
  logic               stop_q, stop_d;
  logic               nack_q, nack_d;
  logic [ByteW-1:0]   last_read_q, last_read_d;

  logic               out_valid_q;
  logic               take;
  logic               finish;
  logic               reject;
  logic               done;
  logic [StatusW-1:0] status;
  logic [DelayW-1:0]  delay_eff;
  logic [ByteW-1:0]   shift_left;

  // A request is taken when the output register is free or being drained.
  assign take       = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign cmd_pop_o  = take;
  assign delay_eff  = (delay_ticks_i == '0) ? DelayW'(1) : delay_ticks_i;
  assign shift_left = {shift_q[ByteW-2:0], 1'b0};

  // Next-state logic of the sequencer.
  always_comb begin
    phase_d     = phase_q;
    wait_d      = wait_q;
    bit_d       = bit_q;
    shift_d     = shift_q;
    scl_d       = scl_q;
    sda_d       = sda_q;
    open_d      = open_q;
    reading_d   = reading_q;
    stop_d      = stop_q;
    nack_d      = nack_q;
    last_read_d = last_read_q;
    finish      = 1'b0;
    case (cmd_i.kind)
      CMD_TICK: begin
        if (phase_q != PH_IDLE) begin
          if (wait_q > DelayW'(1)) begin
            wait_d = wait_q - 1'b1;
          end else begin
            wait_d = delay_eff;
            case (phase_q)
              PH_START_A: begin
                sda_d   = 1'b0;
                phase_d = PH_START_B;
              end
              PH_START_B: begin
                scl_d   = 1'b0;
                sda_d   = shift_q[ByteW-1];
                bit_d   = '0;
                phase_d = PH_WBIT_LOW;
              end
              PH_WBIT_LOW: begin
                scl_d   = 1'b1;
                phase_d = PH_WBIT_HIGH;
              end
              PH_WBIT_HIGH: begin
                scl_d   = 1'b0;
                shift_d = shift_left;
                bit_d   = bit_q + 1'b1;
                if (bit_d < BitsPerByte) begin
                  sda_d   = shift_left[ByteW-1];
                  phase_d = PH_WBIT_LOW;
                end else begin
                  sda_d   = 1'b1;
                  phase_d = PH_WACK_LOW;
                end
              end
              PH_WACK_LOW: begin
                scl_d   = 1'b1;
                phase_d = PH_WACK_HIGH;
              end
              PH_WACK_HIGH: begin
                nack_d = cmd_i.sda_in;
                scl_d  = 1'b0;
                if (cmd_i.sda_in || stop_q) begin
                  sda_d   = 1'b0;
                  phase_d = PH_STOP_A;
                end else begin
                  phase_d = PH_IDLE;
                  wait_d  = '0;
                  finish  = 1'b1;
                end
              end
              PH_RBIT_HIGH: begin
                shift_d = {shift_q[ByteW-2:0], cmd_i.sda_in};
                scl_d   = 1'b0;
                bit_d   = bit_q + 1'b1;
                phase_d = PH_RBIT_LOW;
              end
              PH_RBIT_LOW: begin
                if (bit_q < BitsPerByte) begin
                  scl_d   = 1'b1;
                  phase_d = PH_RBIT_HIGH;
                end else begin
                  // ACK unless this is the last byte of the transfer.
                  sda_d   = stop_q;
                  phase_d = PH_RACK_LOW;
                end
              end
              PH_RACK_LOW: begin
                scl_d   = 1'b1;
                phase_d = PH_RACK_HIGH;
              end
              PH_RACK_HIGH: begin
                scl_d       = 1'b0;
                last_read_d = shift_q;
                if (stop_q) begin
                  sda_d   = 1'b0;
                  phase_d = PH_STOP_A;
                end else begin
                  sda_d   = 1'b1;
                  phase_d = PH_IDLE;
                  wait_d  = '0;
                  finish  = 1'b1;
                end
              end
              PH_STOP_A: begin
                scl_d   = 1'b1;
                phase_d = PH_STOP_B;
              end
              PH_STOP_B: begin
                sda_d   = 1'b1;
                phase_d = PH_STOP_C;
              end
              default: begin
                // Stop condition complete: the bus is released.
                open_d  = 1'b0;
                phase_d = PH_IDLE;
                wait_d  = '0;
                finish  = 1'b1;
              end
            endcase
          end
        end
      end
      CMD_ADDR: begin
        if (phase_q == PH_IDLE) begin
          shift_d   = cmd_i.byte_val;
          reading_d = cmd_i.rnw;
          stop_d    = cmd_i.stop;
          nack_d    = 1'b0;
          open_d    = 1'b1;
          sda_d     = 1'b1;
          scl_d     = 1'b1;
          phase_d   = PH_START_A;
          wait_d    = delay_eff;
        end
      end
      CMD_WRITE: begin
        if (phase_q == PH_IDLE && open_q && !reading_q) begin
          shift_d = cmd_i.byte_val;
          stop_d  = cmd_i.stop;
          nack_d  = 1'b0;
          bit_d   = '0;
          scl_d   = 1'b0;
          sda_d   = cmd_i.byte_val[ByteW-1];
          phase_d = PH_WBIT_LOW;
          wait_d  = delay_eff;
        end
      end
      CMD_READ: begin
        if (phase_q == PH_IDLE && open_q && reading_q) begin
          shift_d = '0;
          stop_d  = cmd_i.stop;
          nack_d  = 1'b0;
          bit_d   = '0;
          sda_d   = 1'b1;
          scl_d   = 1'b1;
          phase_d = PH_RBIT_HIGH;
          wait_d  = delay_eff;
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase
  end

  // Completion flags and status of the current request.
  always_comb begin
    case (cmd_i.kind)
      CMD_TICK: begin
        reject = 1'b0;
      end
      CMD_ADDR: begin
        reject = (phase_q != PH_IDLE);
      end
      CMD_WRITE: begin
        reject = (phase_q != PH_IDLE) || !open_q || reading_q;
      end
      CMD_READ: begin
        reject = (phase_q != PH_IDLE) || !open_q || !reading_q;
      end
      default: begin
        reject = 1'b0;
      end
    endcase
    done = reject || finish;
    if (reject) begin
      status = STATUS_REJECT;
    end else if (finish && nack_d) begin
      status = STATUS_NACK;
    end else begin
      status = STATUS_OK;
    end
  end

  // Sequencer state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      wait_q      <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      open_q      <= 1'b0;
      reading_q   <= 1'b0;
      stop_q      <= 1'b0;
      nack_q      <= 1'b0;
      last_read_q <= '0;
    end else if (take) begin
      phase_q     <= phase_d;
      wait_q      <= wait_d;
      bit_q       <= bit_d;
      shift_q     <= shift_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      open_q      <= open_d;
      reading_q   <= reading_d;
      stop_q      <= stop_d;
      nack_q      <= nack_d;
      last_read_q <= last_read_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (take) begin
      scl_out_o   <= scl_d;
      sda_out_o   <= sda_d;
      busy_res_o  <= (phase_d != PH_IDLE);
      done_res_o  <= done;
      status_o    <= status;
      read_data_o <= last_read_d;
      bus_open_o  <= open_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/i2c_master_bit_sequencer_core.sv =====
// Path: a request accepted at the input is written into the command queue,
// then taken by the pin sequencer into its output register when not stalled.
// Throughput: one request per cycle while the result channel does not stall,
// set by the pin sequencer taking one queued request per cycle into its output register.
// Reset: asynchronous, active low; the bus is released and delay_ticks is 5.
// ----------------------------------------------------------------------------
// I2C master bit sequencer core
// Top level: command decoder, command queue, pin sequencer and the
// delay_ticks configuration register.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_core import i2cm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write channel.
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [DelayW-1:0]  cfg_delay_ticks_i,
  // Input request channel.
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [OpW-1:0]     operation_i,
  input  logic               sda_in_i,
  input  logic [AddrW-1:0]   address_i,
  input  logic               read_not_write_i,
  input  logic [ByteW-1:0]   write_data_i,
  input  logic               stop_after_i,
  // Result channel.
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               scl_out_o,
  output logic               sda_out_o,
  output logic               busy_res_o,
  output logic               done_res_o,
  output logic [StatusW-1:0] status_o,
  output logic [ByteW-1:0]   read_data_o,
  output logic               bus_open_o
);

  logic              push;
  logic              queue_ready;
  logic              queue_valid;
  logic              pop;
  cmd_t              push_cmd;
  cmd_t              pop_cmd;
  logic [DelayW-1:0] delay_q;

  // Configuration register, always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DelayReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      delay_q <= cfg_delay_ticks_i;
    end
  end

  // Decoder.
  i2cm_front u_front (
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .sda_in_i         (sda_in_i),
    .address_i        (address_i),
    .read_not_write_i (read_not_write_i),
    .write_data_i     (write_data_i),
    .stop_after_i     (stop_after_i),
    .queue_ready_i    (queue_ready),
    .push_o           (push),
    .cmd_o            (push_cmd)
  );

  // Command queue.
  i2cm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .ready_o     (queue_ready),
    .valid_o     (queue_valid),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd)
  );

  // Pin sequencer.
  i2cm_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .delay_ticks_i (delay_q),
    .cmd_valid_i   (queue_valid),
    .cmd_i         (pop_cmd),
    .cmd_pop_o     (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .scl_out_o     (scl_out_o),
    .sda_out_o     (sda_out_o),
    .busy_res_o    (busy_res_o),
    .done_res_o    (done_res_o),
    .status_o      (status_o),
    .read_data_o   (read_data_o),
    .bus_open_o    (bus_open_o)
  );

endmodule
